// ----- src/whf_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted histogram fill: shared definitions
// Widths, request and outcome codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package whf_pkg;

   localparam int MAX_BINS = 1024;
   localparam int BIN_AW   = $clog2(MAX_BINS);
   localparam int BINS_W   = 11;
   localparam int WSUM_W   = 48;
   localparam int SQ_W     = 63;
   localparam int CNT_W    = 32;
   localparam int WORD_W   = WSUM_W + SQ_W + CNT_W;
   localparam int DIV_STEPS = BINS_W;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 256;

   localparam logic [1:0] REQ_FILL  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [2:0] OUT_BINNED  = 3'd0;
   localparam logic [2:0] OUT_UNDER   = 3'd1;
   localparam logic [2:0] OUT_OVER    = 3'd2;
   localparam logic [2:0] OUT_DROPPED = 3'd3;
   localparam logic [2:0] OUT_DONE    = 3'd4;

   localparam logic [1:0] CSR_RANGE_LOW  = 2'd0;
   localparam logic [1:0] CSR_RANGE_HIGH = 2'd1;
   localparam logic [1:0] CSR_BINS       = 2'd2;

   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_CLASS = 8'b0000_0100,
      ST_MUL   = 8'b0000_1000,
      ST_DIV   = 8'b0001_0000,
      ST_RD    = 8'b0010_0000,
      ST_UPD   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

endpackage

`default_nettype wire

// ----- src/whf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module whf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- src/weighted_histogram_fill.sv -----
// Fill: classify, multiply, restoring divide, bin read, bin update, then result;
// a sample outside the edges goes from classify to the result. Read: classify,
// bin read, bin update, result. Clear: one bin per cycle through the store.
// One request at a time; the next is taken while the last result waits at rsp_.
// After reset a clearing pass over every bin runs with req_tready low.
// Reset is synchronous and active high; registers return to 0, 65536 and 50.
// ----------------------------------------------------------------------------
// Weighted histogram fill
// Equal-width binning with a restoring divider and a bin store in RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_histogram_fill import whf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // sample_value[31:0], sample_weight[63:32], read_index[73:64], zeros above
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // req_type[1:0]
   input  wire logic [1:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // bin_used[9:0], bin_weight_sum[57:10], bin_weight_sq_sum[120:58],
   // bin_hits[152:121], total_fills[184:153], below_count[216:185],
   // above_count[248:217], zeros above
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // outcome[2:0]
   output logic [2:0]                 rsp_tuser,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_addr,
   input  wire logic [31:0]           csr_wdata
);

   state_type state_ff, state_in;
   logic signed [31:0] low_ff, low_in, high_ff, high_in;
   logic [BINS_W-1:0] bins_ff, bins_in;
   logic [BIN_AW-1:0] clr_cnt_ff, clr_cnt_in;
   logic clr_rsp_ff, clr_rsp_in;
   logic [1:0] type_ff, type_in;
   logic signed [31:0] x_ff, x_in, w_ff, w_in;
   logic [BIN_AW-1:0] ri_ff, ri_in;
   logic [BINS_W-1:0] lowbits_ff, lowbits_in;
   logic [32:0] rem_ff, rem_in;
   logic [BINS_W-1:0] quo_ff, quo_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [SQ_W-1:0] sq_ff, sq_in;
   logic [CNT_W-1:0] fills_ff, fills_in, below_ff, below_in, above_ff, above_in;
   logic [2:0] res_out_ff, res_out_in;
   logic [BIN_AW-1:0] res_bin_ff, res_bin_in;
   logic [WSUM_W-1:0] res_wsum_ff, res_wsum_in;
   logic [SQ_W-1:0] res_sq_ff, res_sq_in;
   logic [CNT_W-1:0] res_hits_ff, res_hits_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_user_ff, rsp_user_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [BINS_W-1:0] eff_bins;
   logic [32:0] span, diff;
   logic [43:0] product;
   logic [31:0] mag;
   logic [63:0] mag_sq;
   logic [33:0] trial;
   logic mem_we;
   logic [BIN_AW-1:0] mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;
   logic [WSUM_W-1:0] old_wsum;
   logic [SQ_W-1:0] old_sq;
   logic [CNT_W-1:0] old_hits;
   logic signed [WSUM_W:0] wsum_add;
   logic [SQ_W:0] sq_add;
   logic req_fire;

   assign eff_bins = (bins_ff > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bins_ff;
   assign span = {high_ff[31], high_ff} - {low_ff[31], low_ff};
   assign diff = {x_ff[31], x_ff} - {low_ff[31], low_ff};
   assign product = diff * eff_bins;
   assign mag = w_ff[31] ? 32'(-w_ff) : 32'(w_ff);
   assign mag_sq = {32'd0, mag} * {32'd0, mag};
   assign trial = {rem_ff, lowbits_ff[BINS_W-1]};
   assign {old_hits, old_sq, old_wsum} = mem_rdata;
   assign wsum_add = {old_wsum[WSUM_W-1], old_wsum} + (WSUM_W+1)'(w_ff);
   assign sq_add = {1'b0, old_sq} + {1'b0, sq_ff};
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;

   whf_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BINS)) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_comb begin
      state_in = state_ff;
      low_in = low_ff;
      high_in = high_ff;
      bins_in = bins_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_rsp_in = clr_rsp_ff;
      type_in = type_ff;
      x_in = x_ff;
      w_in = w_ff;
      ri_in = ri_ff;
      lowbits_in = lowbits_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      sq_in = sq_ff;
      fills_in = fills_ff;
      below_in = below_ff;
      above_in = above_ff;
      res_out_in = res_out_ff;
      res_bin_in = res_bin_ff;
      res_wsum_in = res_wsum_ff;
      res_sq_in = res_sq_ff;
      res_hits_in = res_hits_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_user_in = rsp_user_ff;
      rsp_data_in = rsp_data_ff;
      mem_we = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = '0;
      mem_raddr = (type_ff == REQ_FILL) ? quo_ff[BIN_AW-1:0] : ri_ff;

      if (csr_we) begin
         case (csr_addr)
            CSR_RANGE_LOW: low_in = csr_wdata;
            CSR_RANGE_HIGH: high_in = csr_wdata;
            CSR_BINS: bins_in = csr_wdata[BINS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               res_out_in = OUT_DONE;
               res_bin_in = '0;
               res_wsum_in = '0;
               res_sq_in = '0;
               res_hits_in = '0;
               state_in = clr_rsp_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               type_in = req_tuser;
               x_in = req_tdata[31:0];
               w_in = req_tdata[63:32];
               ri_in = req_tdata[64 +: BIN_AW];
               if (req_tuser == REQ_CLEAR) begin
                  fills_in = '0;
                  below_in = '0;
                  above_in = '0;
                  clr_cnt_in = '0;
                  clr_rsp_in = 1'b1;
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_CLASS;
               end
            end
         end
         ST_CLASS: begin
            res_out_in = OUT_DONE;
            res_bin_in = '0;
            res_wsum_in = '0;
            res_sq_in = '0;
            res_hits_in = '0;
            case (type_ff)
               REQ_FILL: begin
                  if (~&fills_ff) fills_in = fills_ff + 1'b1;
                  if (x_ff < low_ff) begin
                     if (~&below_ff) below_in = below_ff + 1'b1;
                     res_out_in = OUT_UNDER;
                     state_in = ST_OUT;
                  end else if (x_ff > high_ff) begin
                     if (~&above_ff) above_in = above_ff + 1'b1;
                     res_out_in = OUT_OVER;
                     state_in = ST_OUT;
                  end else begin
                     state_in = ST_MUL;
                  end
               end
               REQ_READ: state_in = ST_RD;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_MUL: begin
            // The quotient is at most the bin count, so the top bits of the
            // product already sit below the span and seed the remainder.
            rem_in = product[43:BINS_W];
            lowbits_in = product[BINS_W-1:0];
            sq_in = mag_sq[SQ_W-1:0];
            quo_in = '0;
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (trial >= {1'b0, span}) begin
               rem_in = 33'(trial - {1'b0, span});
               quo_in = {quo_ff[BINS_W-2:0], 1'b1};
            end else begin
               rem_in = trial[32:0];
               quo_in = {quo_ff[BINS_W-2:0], 1'b0};
            end
            lowbits_in = {lowbits_ff[BINS_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 4'(DIV_STEPS - 1)) begin
               if (span != '0 && quo_in < eff_bins) begin
                  state_in = ST_RD;
               end else begin
                  res_out_in = OUT_DROPPED;
                  state_in = ST_OUT;
               end
            end
         end
         ST_RD: state_in = ST_UPD;
         ST_UPD: begin
            if (type_ff == REQ_FILL) begin
               mem_we = 1'b1;
               mem_waddr = quo_ff[BIN_AW-1:0];
               res_out_in = OUT_BINNED;
               res_bin_in = quo_ff[BIN_AW-1:0];
               if (wsum_add[WSUM_W] != wsum_add[WSUM_W-1]) begin
                  res_wsum_in = {wsum_add[WSUM_W], {(WSUM_W-1){~wsum_add[WSUM_W]}}};
               end else begin
                  res_wsum_in = wsum_add[WSUM_W-1:0];
               end
               res_sq_in = sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
               res_hits_in = (&old_hits) ? old_hits : old_hits + 1'b1;
               mem_wdata = {res_hits_in, res_sq_in, res_wsum_in};
            end else begin
               res_bin_in = ri_ff;
               if ({1'b0, ri_ff} < eff_bins) begin
                  res_wsum_in = old_wsum;
                  res_sq_in = old_sq;
                  res_hits_in = old_hits;
               end
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in = res_out_ff;
               rsp_data_in = {7'd0, above_ff, below_ff, fills_ff, res_hits_ff,
                              res_sq_ff, res_wsum_ff, res_bin_ff};
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         low_ff <= '0;
         high_ff <= 32'sd65536;
         bins_ff <= BINS_W'(50);
         clr_cnt_ff <= '0;
         clr_rsp_ff <= 1'b0;
         fills_ff <= '0;
         below_ff <= '0;
         above_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         low_ff <= low_in;
         high_ff <= high_in;
         bins_ff <= bins_in;
         clr_cnt_ff <= clr_cnt_in;
         clr_rsp_ff <= clr_rsp_in;
         fills_ff <= fills_in;
         below_ff <= below_in;
         above_ff <= above_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      x_ff <= x_in;
      w_ff <= w_in;
      ri_ff <= ri_in;
      lowbits_ff <= lowbits_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      sq_ff <= sq_in;
      res_out_ff <= res_out_in;
      res_bin_ff <= res_bin_in;
      res_wsum_ff <= res_wsum_in;
      res_sq_ff <= res_sq_in;
      res_hits_ff <= res_hits_in;
      rsp_user_ff <= rsp_user_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tdata = rsp_data_ff;

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_UPD || state_ff == ST_CLEAR))
      else $error("bin store written outside update or clearing");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request taken while the previous one is in progress");

   a_binned_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == OUT_BINNED) |-> ({1'b0, rsp_tdata[9:0]} < eff_bins))
      else $error("binned result outside the bins in use");

   a_below_bounded: assert property (@(posedge clock) disable iff (reset)
      (below_ff != $past(below_ff)) |-> (fills_ff != $past(fills_ff) || below_ff == '0))
      else $error("underflow counted without a fill");

endmodule

`default_nettype wire
